FILE: src/assert_macros.svh
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; compiled out when SYNTHESIS is defined.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define PLT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition must never be seen outside reset
`define PLT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define PLT_ASSERT(label, clk, rst_n, prop)
`define PLT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: src/plt_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the ping listener table.
// ------------------------------------------------------------------------
package plt_pkg;

	localparam int unsigned SLOTS_DEF  = 16;
	localparam int unsigned ID_W       = 16;
	localparam int unsigned SEQ_W      = 16;
	localparam int unsigned SLOT_IDX_W = 4;

	typedef enum logic [1:0] {
		FUNC_REGISTER = 2'd0,
		FUNC_REPLY    = 2'd1,
		FUNC_POLL     = 2'd2
	} func_t;

	// item travelling down the slot chain
	typedef struct packed {
		logic                  valid;
		func_t                 func;
		logic [ID_W-1:0]       id;
		logic [SEQ_W-1:0]      seq;   // poll hit: replaced by stored seq
		logic                  hit;
		logic [SLOT_IDX_W-1:0] slot;  // low bits of the matching slot number
	} tok_t;

endpackage

FILE: src/plt_cell.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// plt_cell
// One table slot: holds id, seq and received flag, serves a passing item.
// ------------------------------------------------------------------------
module plt_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  plt_pkg::tok_t tok_in,
	output plt_pkg::tok_t tok_out
);

	localparam int unsigned TAG_W = plt_pkg::SLOT_IDX_W;
	localparam logic [TAG_W-1:0] SLOT_TAG = TAG_W'(IDX);

	logic [plt_pkg::ID_W-1:0]  id_q;
	logic [plt_pkg::SEQ_W-1:0] seq_q;
	logic                      rcv_q;
	logic                      take;
	plt_pkg::tok_t             tok_nxt;
	plt_pkg::tok_t             tok_q;

	// first qualifying slot claims the item; later cells see hit set
	always_comb begin
		take = 1'b0;
		if (tok_in.valid && !tok_in.hit) begin
			unique case (tok_in.func)
				plt_pkg::FUNC_REGISTER: take = (id_q == '0) || (id_q == tok_in.id);
				plt_pkg::FUNC_REPLY:    take = (id_q == tok_in.id);
				plt_pkg::FUNC_POLL:     take = (id_q == tok_in.id) && rcv_q;
				default:                take = 1'b0;
			endcase
		end
	end

	always_comb begin
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.hit  = 1'b1;
			tok_nxt.slot = SLOT_TAG;
			if (tok_in.func == plt_pkg::FUNC_POLL) begin
				tok_nxt.seq = seq_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q  <= '0;
			seq_q <= '0;
			rcv_q <= 1'b0;
		end else if (take) begin
			case (tok_in.func)
				plt_pkg::FUNC_REGISTER: begin
					id_q  <= tok_in.id;
					seq_q <= tok_in.seq;
					rcv_q <= 1'b0;
				end
				plt_pkg::FUNC_REPLY: begin
					seq_q <= tok_in.seq;
					rcv_q <= 1'b1;
				end
				plt_pkg::FUNC_POLL: begin
					rcv_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: src/ping_listener_table_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// ping_listener_table_unit
// Echo listener table: register, reply and poll items on a chain of slots.
// ------------------------------------------------------------------------
// Chain: cell 0 works on the item straight from the ports in the
//   accepting cycle, then one slot cell per cycle, done high in the last.
// Flow: one item in flight at a time; busy rises at the accepting edge
//   and falls at the result edge.
// Reset: arst_n clears every slot (id 0 = free, seq 0, not received) and
//   the chain at once; no clearing pass. The receiver cannot stall, so
//   done is a single-cycle strobe.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module ping_listener_table_unit #(
	parameter int unsigned SLOTS = plt_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [plt_pkg::ID_W-1:0]        echo_id,
	input  logic [plt_pkg::SEQ_W-1:0]       echo_seq,
	// result side
	output logic                            done,
	output logic                            hit,
	output logic [plt_pkg::SLOT_IDX_W-1:0]  slot_index,
	output logic [plt_pkg::SEQ_W-1:0]       seq_out
);

	// tok[i] enters cell i; tok[SLOTS] is the finished item
	plt_pkg::tok_t tok [SLOTS+1];
	logic          accept;
	logic          busy_q;
	logic [SLOTS:0] tok_valid;

	assign accept = start && !busy_q;

	// item enters slot 0 straight from the ports in the accepting cycle
	always_comb begin
		tok[0]       = '0;
		tok[0].valid = accept;
		tok[0].func  = plt_pkg::func_t'(func);
		tok[0].id    = echo_id;
		tok[0].seq   = echo_seq;
	end

	// slot chain: lowest index first, so the first match wins
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		plt_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	// one item in flight at a time; freed after its result cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (tok[SLOTS].valid) begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// result: all fields zero on a miss; seq only for a poll hit
	assign done       = tok[SLOTS].valid;
	assign hit        = tok[SLOTS].hit;
	assign slot_index = tok[SLOTS].hit ? tok[SLOTS].slot : '0;
	assign seq_out    = (tok[SLOTS].hit && (tok[SLOTS].func == plt_pkg::FUNC_POLL))
	                    ? tok[SLOTS].seq : '0;

	for (genvar k = 0; k <= SLOTS; k++) begin : g_vld
		assign tok_valid[k] = tok[k].valid;
	end

	// at most one item anywhere in the chain
	`PLT_ASSERT(a_single_item, clk, arst_n, $onehot0(tok_valid))
	// a result only appears while the item is still owned
	`PLT_ASSERT(a_done_busy, clk, arst_n, done |-> busy)
	// accepting locks out the next command
	`PLT_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy)
	// a miss reports nothing else
	`PLT_ASSERT_NEVER(a_miss_clean, clk, arst_n, done && !hit && ((slot_index != '0) || (seq_out != '0)))

endmodule

FILE: tb/sv/ping_listener_table_unit_tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// ping_listener_table_unit_tb
// Self-checking bench for the echo listener table. A queue of register,
// reply and poll items feeds a falling-edge driver that sends in bursts.
// A rising-edge monitor runs every accepted item through a shadow copy
// of the slot table and checks each done strobe against the oldest
// predicted answer.
// ------------------------------------------------------------------------
module ping_listener_table_unit_tb;
	import plt_pkg::*;

	localparam int NUM_SLOTS    = SLOTS_DEF;
	localparam int LATENCY      = NUM_SLOTS;      // sizes the end-of-run tail
	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT  = 400000;         // slowest run is far below this
	localparam int MAX_REPORTS  = 10;
	localparam int STRAY_IDS    = 4;

	// func code outside the enum; the block must answer all zero
	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [ID_W-1:0]  id;
		logic [SEQ_W-1:0] seq;
	} echo_cmd_t;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_IDX_W-1:0] slot;
		logic [SEQ_W-1:0]      seq;
	} echo_answer_t;

	// clock, reset and block ports; every input known from time zero
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic [1:0]            func       = '0;
	logic [ID_W-1:0]       echo_id    = '0;
	logic [SEQ_W-1:0]      echo_seq   = '0;
	logic                  busy;
	logic                  done;
	logic                  hit;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [SEQ_W-1:0]      seq_out;

	// items waiting to be sent, answers waiting to arrive
	echo_cmd_t    pending_items[$];
	echo_answer_t expected_answers[$];

	// shadow slot table
	logic [ID_W-1:0]  shadow_id   [NUM_SLOTS];
	logic [SEQ_W-1:0] shadow_seq  [NUM_SLOTS];
	logic             shadow_rcvd [NUM_SLOTS];

	// id pools used to steer random traffic onto live slots
	logic [ID_W-1:0] known_ids [NUM_SLOTS];
	logic [ID_W-1:0] stray_ids [STRAY_IDS];

	logic took_item = 1'b0;  // start && !busy seen at the last rising edge
	int   burst_left = 1;
	int   gap_left   = 0;
	int   cycle_count = 0;
	int   errors = 0;
	int   items_queued = 0;
	int   directed_items = 0;
	int   items_sent = 0;
	int   answers_checked = 0;
	int   hit_tally [4] = '{0, 0, 0, 0};

	ping_listener_table_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.echo_id    (echo_id),
		.echo_seq   (echo_seq),
		.done       (done),
		.hit        (hit),
		.slot_index (slot_index),
		.seq_out    (seq_out)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_id[i]   = '0;
			shadow_seq[i]  = '0;
			shadow_rcvd[i] = 1'b0;
		end
	end

	// Apply one item to the shadow table and return the answer it causes.
	// Every scan stops at the lowest qualifying slot; id 0 matches free slots.
	function automatic echo_answer_t listener_apply(echo_cmd_t cmd);
		echo_answer_t ans;
		logic         found;
		ans   = '0;
		found = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!found) begin
				case (cmd.func)
					FUNC_REGISTER: begin
						// free slot or same id: claim it, pending reply dropped
						if (shadow_id[i] == '0 || shadow_id[i] == cmd.id) begin
							shadow_id[i]   = cmd.id;
							shadow_seq[i]  = cmd.seq;
							shadow_rcvd[i] = 1'b0;
							ans.slot       = SLOT_IDX_W'(i);
							found          = 1'b1;
						end
					end
					FUNC_REPLY: begin
						if (shadow_id[i] == cmd.id) begin
							shadow_seq[i]  = cmd.seq;
							shadow_rcvd[i] = 1'b1;
							ans.slot       = SLOT_IDX_W'(i);
							found          = 1'b1;
						end
					end
					FUNC_POLL: begin
						// only a slot with a reply pending counts
						if (shadow_id[i] == cmd.id && shadow_rcvd[i]) begin
							shadow_rcvd[i] = 1'b0;
							ans.slot       = SLOT_IDX_W'(i);
							ans.seq        = shadow_seq[i];
							found          = 1'b1;
						end
					end
					default: begin
						// unknown func: no slot touched, answer stays zero
					end
				endcase
			end
		end
		ans.hit = found;
		return ans;
	endfunction

	task automatic add_cmd(input logic [1:0] f, input logic [ID_W-1:0] id,
			input logic [SEQ_W-1:0] seq);
		pending_items.push_back('{f, id, seq});
		items_queued++;
	endtask

	// mostly ids that own a slot, some that never will, now and then zero
	// or a fully random id
	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return known_ids[$urandom_range(0, NUM_SLOTS - 1)];
		else if (r < 17)
			return stray_ids[$urandom_range(0, STRAY_IDS - 1)];
		else if (r < 18)
			return '0;
		else
			return ID_W'($urandom);
	endfunction

	// ----------------------------------------------------------------
	// Driver: presents the queue head on the falling edge and holds it
	// until the monitor reports it taken. Items go out in bursts; about
	// a third of the bursts follow straight on, the rest after a gap.
	// ----------------------------------------------------------------
	always @(negedge clk) begin : driver_proc
		logic drive;
		if (arst_n) begin
			if (took_item)
				pending_items.delete(0);
			// still waiting on busy: keep the same item up
			drive = start && !took_item;
			if (!drive && pending_items.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					drive = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left--;
					end
				end
			end
			start <= drive;
			if (drive) begin
				func     <= pending_items[0].func;
				echo_id  <= pending_items[0].id;
				echo_seq <= pending_items[0].seq;
			end
		end
	end

	// ----------------------------------------------------------------
	// Monitor: on the rising edge, an item with start high and busy low
	// is taken and predicted; a done strobe is checked against the oldest
	// prediction, field by field.
	// ----------------------------------------------------------------
	always @(posedge clk) begin : monitor_proc
		echo_answer_t got;
		echo_answer_t want;
		echo_cmd_t    cmd;
		if (!arst_n) begin
			took_item <= 1'b0;
		end else begin
			took_item <= start && !busy;
			if (done) begin
				got = {hit, slot_index, seq_out};
				if (expected_answers.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("ERROR: answer with none pending: hit %0b slot %0d seq %h",
							got.hit, got.slot, got.seq);
				end else begin
					want = expected_answers.pop_front();
					answers_checked++;
					if (got.hit !== want.hit || got.slot !== want.slot ||
							got.seq !== want.seq) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("ERROR: answer %0d: expected hit %0b slot %0d seq %h, got hit %0b slot %0d seq %h",
								answers_checked, want.hit, want.slot, want.seq,
								got.hit, got.slot, got.seq);
					end
				end
			end
			if (start && !busy) begin
				cmd  = {func, echo_id, echo_seq};
				want = listener_apply(cmd);
				expected_answers.push_back(want);
				hit_tally[cmd.func] += want.hit;
				items_sent++;
			end
		end
	end

	// run watchdog
	initial begin : watchdog_proc
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: no finish after %0d cycles", CYCLE_LIMIT);
		$display("ping_listener_table_unit verification failed");
		$finish;
	end

	initial begin : stimulus_proc
		logic [ID_W-1:0]  id;
		logic [SEQ_W-1:0] s1;
		logic [SEQ_W-1:0] s2;
		int               kind;

		known_ids[0] = 16'hFFFF;
		for (int k = 1; k < NUM_SLOTS; k++)
			known_ids[k] = ID_W'(16'h0101 * k);
		for (int k = 0; k < STRAY_IDS; k++)
			stray_ids[k] = {1'b1, 15'($urandom)} ^ 16'h00F0;

		// -- directed part --
		// empty table: poll of id 0 finds nothing pending
		add_cmd(FUNC_POLL, 16'h0000, 16'hFFFF);
		// id 0 reply lands on free slot 0, which stays free
		add_cmd(FUNC_REPLY, 16'h0000, 16'hA5A5);
		// and the poll collects it
		add_cmd(FUNC_POLL, 16'h0000, 16'h0000);
		// registering id 0 claims slot 0 without taking it
		add_cmd(FUNC_REGISTER, 16'h0000, 16'h0000);
		// extreme id and seq into slot 0
		add_cmd(FUNC_REGISTER, 16'hFFFF, 16'hFFFF);
		// unknown func: nothing changes
		add_cmd(FUNC_UNKNOWN, 16'hFFFF, 16'hFFFF);
		add_cmd(FUNC_REPLY, 16'hFFFF, 16'hFFFF);
		add_cmd(FUNC_POLL, 16'hFFFF, 16'h0000);
		// second poll: reply already taken
		add_cmd(FUNC_POLL, 16'hFFFF, 16'h0000);
		// reply to an id nobody holds
		add_cmd(FUNC_REPLY, 16'h1234, 16'h0001);
		// fill the remaining slots, then one more: table full
		for (int k = 1; k < NUM_SLOTS; k++)
			add_cmd(FUNC_REGISTER, known_ids[k], SEQ_W'($urandom));
		add_cmd(FUNC_REGISTER, 16'h7FFF, 16'h8000);
		directed_items = items_queued;

		// -- random part: mostly complete exchanges, some broken or noise --
		while (items_queued < directed_items + RANDOM_ITEMS) begin
			id   = pick_id();
			s1   = SEQ_W'($urandom);
			s2   = SEQ_W'($urandom);
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					add_cmd(FUNC_REPLY, id, s1);
					add_cmd(FUNC_POLL, id, s2);
				end
				3: begin
					add_cmd(FUNC_REGISTER, id, s1);
					add_cmd(FUNC_REPLY, id, s2);
					add_cmd(FUNC_POLL, id, s1);
				end
				4: begin
					// newer reply overwrites; second poll misses
					add_cmd(FUNC_REPLY, id, s1);
					add_cmd(FUNC_REPLY, id, s2);
					add_cmd(FUNC_POLL, id, s1);
					add_cmd(FUNC_POLL, id, s2);
				end
				5: begin
					add_cmd(FUNC_POLL, id, s1);
				end
				6: begin
					// re-register drops the pending reply
					add_cmd(FUNC_REPLY, id, s1);
					add_cmd(FUNC_REGISTER, id, s2);
					add_cmd(FUNC_POLL, id, s1);
				end
				default: begin
					add_cmd(2'($urandom_range(0, 3)), ID_W'($urandom), s1);
				end
			endcase
		end

		// reset: held low from time zero, released on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || expected_answers.size() != 0)
			@(posedge clk);
		// any stray strobe would show up within this tail
		repeat (2 * LATENCY) @(posedge clk);

		$display("Sent %0d items (%0d directed), checked %0d answers in %0d cycles",
			items_sent, directed_items, answers_checked, cycle_count);
		$display("Hits: register %0d, reply %0d, poll %0d; mismatches %0d",
			hit_tally[FUNC_REGISTER], hit_tally[FUNC_REPLY], hit_tally[FUNC_POLL], errors);
		if (errors == 0 && expected_answers.size() == 0) begin
			$display("ping_listener_table_unit verification clean");
		end else begin
			$display("ping_listener_table_unit verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/plt_pkg.sv
src/plt_cell.sv
src/ping_listener_table_unit.sv
tb/sv/ping_listener_table_unit_tb.sv
